// File: hw/rtl/l3d_pkg.sv
// ----------------------------------------------------------------------------
// l3d_pkg
// shared types and constants of the 3d lut color mapper
// ----------------------------------------------------------------------------
package l3d_pkg;

   localparam int CHAN_W     = 16;
   localparam int INDEX_W    = 12;
   localparam int DIM_W      = 7;
   localparam int ADDR_SUM_W = 21;   // holds x + y*w + z*w*h for sizes up to 127
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LUMA_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LUT_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LUT_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LUT_DEPTH  = 2'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   typedef struct packed {
      logic                      opcode;
      logic [INDEX_W-1:0]        entry_index;
      logic signed [CHAN_W-1:0]  chan0;
      logic signed [CHAN_W-1:0]  chan1;
      logic signed [CHAN_W-1:0]  chan2;
      logic signed [CHAN_W-1:0]  chan3;
   } req_type;

   typedef struct packed {
      logic signed [CHAN_W-1:0]  out0;
      logic signed [CHAN_W-1:0]  out1;
      logic signed [CHAN_W-1:0]  out2;
      logic signed [CHAN_W-1:0]  out3;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic pixel;
   } stage_ctl_type;

endpackage

// File: hw/rtl/l3d_ram.sv
// ----------------------------------------------------------------------------
// l3d_ram
// table bank: one write port, one registered read port
// ----------------------------------------------------------------------------
module l3d_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 64
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/l3d_addr.sv
// ----------------------------------------------------------------------------
// l3d_addr
// coordinate clamp and scale, corner index build and wrap to table size
// ----------------------------------------------------------------------------
module l3d_addr #(
   parameter int LUT_ENTRIES = 4096,
   parameter int FRAC_BITS   = 14,
   parameter int AW          = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        luma_mode,
   input  logic [l3d_pkg::DIM_W-1:0]   dim_w,
   input  logic [l3d_pkg::DIM_W-1:0]   dim_h,
   input  logic [l3d_pkg::DIM_W-1:0]   dim_d,
   input  l3d_pkg::stage_ctl_type      in_ctl,
   input  l3d_pkg::req_type            in_req,
   output l3d_pkg::stage_ctl_type      out_ctl,
   output l3d_pkg::req_type            out_req,
   output logic [7:0][AW-1:0]          out_addr,
   output logic [FRAC_BITS-1:0]        out_wx,
   output logic [FRAC_BITS-1:0]        out_wy,
   output logic [FRAC_BITS-1:0]        out_wz
);
   import l3d_pkg::*;

   localparam int PW  = (FRAC_BITS + 8 > 37) ? FRAC_BITS + 8 : 37;
   localparam int VW  = ADDR_SUM_W;
   localparam int NW  = 17;
   localparam int WHW = 2 * DIM_W;
   localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;
   localparam longint RECIP_L = (longint'(1) << VW) / LUT_ENTRIES;
   localparam logic [VW-1:0] RECIP = RECIP_L[VW-1:0];
   localparam logic [AW:0] N_R = (AW+1)'(LUT_ENTRIES);

   function automatic logic [15:0] clamp_c(input logic signed [15:0] c);
      logic [15:0] r;
      if (c < 0) begin
         r = '0;
      end else if ({16'h0, c} > ONE) begin
         r = ONE[15:0];
      end else begin
         r = c;
      end
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] upper(input logic [DIM_W-1:0] i,
                                              input logic [DIM_W-1:0] n);
      logic [DIM_W:0] i1;
      i1 = {1'b0, i} + 1'b1;
      return (i1 < {1'b0, n}) ? i1[DIM_W-1:0] : n - 1'b1;
   endfunction

   // stage 1: clamp, w*h
   stage_ctl_type    s1_ctl_ff;
   req_type          s1_req_ff;
   logic [15:0]      s1_cx_ff, s1_cy_ff, s1_cz_ff;
   logic [WHW-1:0]   s1_wh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (en) begin
         s1_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_req_ff <= in_req;
         s1_cx_ff  <= clamp_c(in_req.chan0);
         s1_cy_ff  <= clamp_c(in_req.chan1);
         s1_cz_ff  <= clamp_c(in_req.chan2);
         s1_wh_ff  <= WHW'(dim_w) * WHW'(dim_h);
      end
   end

   // stage 2: scale by size-1, w*h*d
   stage_ctl_type    s2_ctl_ff;
   req_type          s2_req_ff;
   logic [PW-1:0]    s2_px_ff, s2_py_ff, s2_pz_ff;
   logic [15:0]      s2_cy_ff;
   logic [WHW-1:0]   s2_wh_ff;
   logic [VW-1:0]    s2_whd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff <= '0;
      end else if (en) begin
         s2_ctl_ff <= s1_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_req_ff <= s1_req_ff;
         s2_px_ff  <= PW'(s1_cx_ff) * PW'(dim_w - 1'b1);
         s2_py_ff  <= PW'(s1_cy_ff) * PW'(dim_h - 1'b1);
         s2_pz_ff  <= PW'(s1_cz_ff) * PW'(dim_d - 1'b1);
         s2_cy_ff  <= s1_cy_ff;
         s2_wh_ff  <= s1_wh_ff;
         s2_whd_ff <= VW'(s1_wh_ff) * VW'(dim_d);
      end
   end

   // stage 3: split integer and fraction, row and plane offsets, luma scale
   logic [DIM_W-1:0] x0, y0, z0;

   always_comb begin
      x0 = DIM_W'(s2_px_ff >> FRAC_BITS);
      y0 = DIM_W'(s2_py_ff >> FRAC_BITS);
      z0 = DIM_W'(s2_pz_ff >> FRAC_BITS);
   end

   stage_ctl_type          s3_ctl_ff;
   req_type                s3_req_ff;
   logic [DIM_W-1:0]       s3_x0_ff, s3_x1_ff;
   logic [WHW-1:0]         s3_y0w_ff, s3_y1w_ff;
   logic [VW-1:0]          s3_z0wh_ff, s3_z1wh_ff, s3_whd_ff;
   logic [FRAC_BITS-1:0]   s3_wx_ff, s3_wy_ff, s3_wz_ff;
   logic [PW-1:0]          s3_pl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else if (en) begin
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_req_ff  <= s2_req_ff;
         s3_x0_ff   <= x0;
         s3_x1_ff   <= upper(x0, dim_w);
         s3_y0w_ff  <= WHW'(y0) * WHW'(dim_w);
         s3_y1w_ff  <= WHW'(upper(y0, dim_h)) * WHW'(dim_w);
         s3_z0wh_ff <= VW'(z0) * VW'(s2_wh_ff);
         s3_z1wh_ff <= VW'(upper(z0, dim_d)) * VW'(s2_wh_ff);
         s3_wx_ff   <= s2_px_ff[FRAC_BITS-1:0];
         s3_wy_ff   <= s2_py_ff[FRAC_BITS-1:0];
         s3_wz_ff   <= s2_pz_ff[FRAC_BITS-1:0];
         s3_pl_ff   <= PW'(s2_cy_ff) * PW'(s2_whd_ff - 1'b1);
         s3_whd_ff  <= s2_whd_ff;
      end
   end

   // stage 4: corner sums; corner k is {z, y, x} upper-select bits
   logic [VW-1:0]          luma_s, luma_t;
   logic [VW:0]            luma_s1;
   logic [7:0][VW-1:0]     v_in;
   logic [FRAC_BITS-1:0]   wx_in, wy_in, wz_in;

   always_comb begin
      luma_s  = VW'(s3_pl_ff >> FRAC_BITS);
      luma_s1 = {1'b0, luma_s} + 1'b1;
      luma_t  = (luma_s1 < {1'b0, s3_whd_ff}) ? luma_s1[VW-1:0] : s3_whd_ff - 1'b1;
      for (int k = 0; k < 8; k++) begin
         if (!s3_req_ff.opcode) begin
            v_in[k] = VW'(s3_req_ff.entry_index);
         end else if (luma_mode) begin
            v_in[k] = ((k & 1) != 0) ? luma_t : luma_s;
         end else begin
            v_in[k] = VW'(((k & 1) != 0) ? s3_x1_ff : s3_x0_ff)
                    + VW'(((k & 2) != 0) ? s3_y1w_ff : s3_y0w_ff)
                    + (((k & 4) != 0) ? s3_z1wh_ff : s3_z0wh_ff);
         end
      end
      // luma: one lerp along the line, the other two axes see zero weight
      wx_in = luma_mode ? s3_pl_ff[FRAC_BITS-1:0] : s3_wx_ff;
      wy_in = luma_mode ? '0 : s3_wy_ff;
      wz_in = luma_mode ? '0 : s3_wz_ff;
   end

   stage_ctl_type          s4_ctl_ff, s5_ctl_ff, s6_ctl_ff, s7_ctl_ff;
   req_type                s4_req_ff, s5_req_ff, s6_req_ff, s7_req_ff;
   logic [FRAC_BITS-1:0]   s4_wx_ff, s5_wx_ff, s6_wx_ff, s7_wx_ff;
   logic [FRAC_BITS-1:0]   s4_wy_ff, s5_wy_ff, s6_wy_ff, s7_wy_ff;
   logic [FRAC_BITS-1:0]   s4_wz_ff, s5_wz_ff, s6_wz_ff, s7_wz_ff;
   logic [7:0][VW-1:0]     s4_v_ff, s5_v_ff, s5_q_ff;
   logic [7:0][AW:0]       s6_r_ff;
   logic [7:0][AW-1:0]     s7_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_ctl_ff <= '0;
         s5_ctl_ff <= '0;
         s6_ctl_ff <= '0;
         s7_ctl_ff <= '0;
      end else if (en) begin
         s4_ctl_ff <= s3_ctl_ff;
         s5_ctl_ff <= s4_ctl_ff;
         s6_ctl_ff <= s5_ctl_ff;
         s7_ctl_ff <= s6_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_req_ff <= s3_req_ff;
         s5_req_ff <= s4_req_ff;
         s6_req_ff <= s5_req_ff;
         s7_req_ff <= s6_req_ff;
         s4_wx_ff  <= wx_in;
         s5_wx_ff  <= s4_wx_ff;
         s6_wx_ff  <= s5_wx_ff;
         s7_wx_ff  <= s6_wx_ff;
         s4_wy_ff  <= wy_in;
         s5_wy_ff  <= s4_wy_ff;
         s6_wy_ff  <= s5_wy_ff;
         s7_wy_ff  <= s6_wy_ff;
         s4_wz_ff  <= wz_in;
         s5_wz_ff  <= s4_wz_ff;
         s6_wz_ff  <= s5_wz_ff;
         s7_wz_ff  <= s6_wz_ff;
         s4_v_ff   <= v_in;
         s5_v_ff   <= s4_v_ff;
         for (int k = 0; k < 8; k++) begin
            // wrap to table size: reciprocal estimate is low by at most one
            s5_q_ff[k]    <= VW'(((2*VW)'(s4_v_ff[k]) * (2*VW)'(RECIP)) >> VW);
            s6_r_ff[k]    <= (AW+1)'((VW+1)'(s5_v_ff[k])
                           - (VW+1)'((VW+NW)'(s5_q_ff[k]) * (VW+NW)'(LUT_ENTRIES)));
            s7_addr_ff[k] <= AW'((s6_r_ff[k] >= N_R) ? s6_r_ff[k] - N_R : s6_r_ff[k]);
         end
      end
   end

   assign out_ctl  = s7_ctl_ff;
   assign out_req  = s7_req_ff;
   assign out_addr = s7_addr_ff;
   assign out_wx   = s7_wx_ff;
   assign out_wy   = s7_wy_ff;
   assign out_wz   = s7_wz_ff;

endmodule

// File: hw/rtl/l3d_interp.sv
// ----------------------------------------------------------------------------
// l3d_interp
// trilinear lerp tree over eight corners, alpha scale and saturation
// ----------------------------------------------------------------------------
module l3d_interp #(
   parameter int FRAC_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  l3d_pkg::stage_ctl_type  in_ctl,
   input  logic signed [15:0]      in_alpha,
   input  logic [FRAC_BITS-1:0]    in_wx,
   input  logic [FRAC_BITS-1:0]    in_wy,
   input  logic [FRAC_BITS-1:0]    in_wz,
   input  logic [63:0]             corner [8],
   output logic                    rsp_valid,
   output l3d_pkg::rsp_type        rsp_data
);
   import l3d_pkg::*;

   localparam int PRW = FRAC_BITS + 18;
   localparam logic signed [PRW-1:0] HALF  = PRW'(1) << (FRAC_BITS - 1);
   localparam logic signed [32:0]    AHALF = 33'(1) << (FRAC_BITS - 1);

   function automatic logic signed [PRW-1:0] lerp_prod(input logic signed [15:0] a,
                                                       input logic signed [15:0] b,
                                                       input logic [FRAC_BITS-1:0] w);
      logic signed [PRW-1:0] d;
      d = PRW'(b) - PRW'(a);
      return d * $signed({1'b0, w});
   endfunction

   function automatic logic signed [15:0] lerp_fin(input logic signed [15:0] a,
                                                   input logic signed [PRW-1:0] p);
      logic signed [PRW-1:0] s;
      s = (p + HALF) >>> FRAC_BITS;
      return 16'(PRW'(a) + s);
   endfunction

   stage_ctl_type          s9_ctl_ff, s10_ctl_ff, s11_ctl_ff, s12_ctl_ff;
   logic signed [15:0]     s9_alpha_ff, s10_alpha_ff, s11_alpha_ff;
   logic [FRAC_BITS-1:0]   s9_wy_ff, s9_wz_ff, s10_wz_ff;
   logic signed [15:0]     s9_a_ff [4][4];
   logic signed [PRW-1:0]  s9_p_ff [4][4];
   logic signed [15:0]     s10_a_ff [2][4];
   logic signed [PRW-1:0]  s10_p_ff [2][4];
   logic signed [15:0]     s11_a_ff [4];
   logic signed [PRW-1:0]  s11_p_ff [4];
   logic signed [15:0]     s12_res_ff [3];
   logic signed [32:0]     s12_ap_ff;
   logic signed [15:0]     ax [4][4];
   logic signed [15:0]     ay [2][4];
   logic signed [15:0]     az [4];
   logic signed [32:0]     ascaled;
   logic signed [15:0]     asat;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   always_comb begin
      for (int p = 0; p < 4; p++) begin
         for (int c = 0; c < 4; c++) begin
            ax[p][c] = lerp_fin(s9_a_ff[p][c], s9_p_ff[p][c]);
         end
      end
      for (int z = 0; z < 2; z++) begin
         for (int c = 0; c < 4; c++) begin
            ay[z][c] = lerp_fin(s10_a_ff[z][c], s10_p_ff[z][c]);
         end
      end
      for (int c = 0; c < 4; c++) begin
         az[c] = lerp_fin(s11_a_ff[c], s11_p_ff[c]);
      end
      ascaled = (s12_ap_ff + AHALF) >>> FRAC_BITS;
      if (ascaled > 33'sd32767) begin
         asat = 16'sh7fff;
      end else if (ascaled < -33'sd32768) begin
         asat = 16'sh8000;
      end else begin
         asat = 16'(ascaled);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_ctl_ff    <= '0;
         s10_ctl_ff   <= '0;
         s11_ctl_ff   <= '0;
         s12_ctl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s9_ctl_ff    <= in_ctl;
         s10_ctl_ff   <= s9_ctl_ff;
         s11_ctl_ff   <= s10_ctl_ff;
         s12_ctl_ff   <= s11_ctl_ff;
         rsp_valid_ff <= s12_ctl_ff.valid && s12_ctl_ff.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s9_alpha_ff  <= in_alpha;
         s10_alpha_ff <= s9_alpha_ff;
         s11_alpha_ff <= s10_alpha_ff;
         s9_wy_ff     <= in_wy;
         s9_wz_ff     <= in_wz;
         s10_wz_ff    <= s9_wz_ff;
         // x lerps: pair p holds corners {z,y,0} and {z,y,1}
         for (int p = 0; p < 4; p++) begin
            for (int c = 0; c < 4; c++) begin
               s9_a_ff[p][c] <= corner[2*p][16*c +: 16];
               s9_p_ff[p][c] <= lerp_prod(corner[2*p][16*c +: 16],
                                          corner[2*p+1][16*c +: 16], in_wx);
            end
         end
         for (int z = 0; z < 2; z++) begin
            for (int c = 0; c < 4; c++) begin
               s10_a_ff[z][c] <= ax[2*z][c];
               s10_p_ff[z][c] <= lerp_prod(ax[2*z][c], ax[2*z+1][c], s9_wy_ff);
            end
         end
         for (int c = 0; c < 4; c++) begin
            s11_a_ff[c] <= ay[0][c];
            s11_p_ff[c] <= lerp_prod(ay[0][c], ay[1][c], s10_wz_ff);
         end
         for (int c = 0; c < 3; c++) begin
            s12_res_ff[c] <= az[c];
         end
         s12_ap_ff <= 33'(s11_alpha_ff) * 33'(az[3]);
         rsp_data_ff.out0 <= s12_res_ff[0];
         rsp_data_ff.out1 <= s12_res_ff[1];
         rsp_data_ff.out2 <= s12_res_ff[2];
         rsp_data_ff.out3 <= asat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/lut3d_trilinear_color_map.sv
// ----------------------------------------------------------------------------
// lut3d_trilinear_color_map
// color lookup through a 3d table with trilinear interpolation
// ----------------------------------------------------------------------------
// One item is taken per clock while the result side does not stall. A pixel's
// result passes the input register, address stages, bank read and lerp stages;
// a table write gives no result and takes the same path, in order with pixels.
// Eight table banks, each a full copy written by every entry write, deliver
// the eight corners in one read; a stall on rsp_ready freezes the whole
// pipeline. Table entries must be written before any pixel reads them.
// ----------------------------------------------------------------------------
module lut3d_trilinear_color_map #(
   parameter int LUT_ENTRIES = 4096,
   parameter int FRAC_BITS   = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  l3d_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output l3d_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [l3d_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [l3d_pkg::DIM_W-1:0]     csr_wr_data
);
   import l3d_pkg::*;

   localparam int AW = $clog2(LUT_ENTRIES);

   logic               luma_mode_ff;
   logic [DIM_W-1:0]   lut_width_ff, lut_height_ff, lut_depth_ff;
   logic [DIM_W-1:0]   dim_w, dim_h, dim_d;
   logic               en;

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_mode_ff  <= 1'b0;
         lut_width_ff  <= DIM_W'(1);
         lut_height_ff <= DIM_W'(1);
         lut_depth_ff  <= DIM_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LUMA_MODE:  luma_mode_ff  <= csr_wr_data[0];
            CSR_LUT_WIDTH:  lut_width_ff  <= csr_wr_data;
            CSR_LUT_HEIGHT: lut_height_ff <= csr_wr_data;
            CSR_LUT_DEPTH:  lut_depth_ff  <= csr_wr_data;
         endcase
      end
   end

   // a size of zero acts as one
   assign dim_w = (lut_width_ff  == '0) ? DIM_W'(1) : lut_width_ff;
   assign dim_h = (lut_height_ff == '0) ? DIM_W'(1) : lut_height_ff;
   assign dim_d = (lut_depth_ff  == '0) ? DIM_W'(1) : lut_depth_ff;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   stage_ctl_type s0_ctl_ff;
   req_type       s0_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
      end else if (en) begin
         s0_ctl_ff.valid <= req_valid;
         s0_ctl_ff.pixel <= (req_data.opcode == OP_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_req_ff <= req_data;
      end
   end

   stage_ctl_type          a_ctl;
   req_type                a_req;
   logic [7:0][AW-1:0]     a_addr;
   logic [FRAC_BITS-1:0]   a_wx, a_wy, a_wz;

   l3d_addr #(
      .LUT_ENTRIES (LUT_ENTRIES),
      .FRAC_BITS   (FRAC_BITS),
      .AW          (AW)
   ) u_addr (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .luma_mode (luma_mode_ff),
      .dim_w     (dim_w),
      .dim_h     (dim_h),
      .dim_d     (dim_d),
      .in_ctl    (s0_ctl_ff),
      .in_req    (s0_req_ff),
      .out_ctl   (a_ctl),
      .out_req   (a_req),
      .out_addr  (a_addr),
      .out_wx    (a_wx),
      .out_wy    (a_wy),
      .out_wz    (a_wz)
   );

   logic        wr_en;
   logic [63:0] wr_data;
   logic [63:0] rd_data [8];

   assign wr_en   = en && a_ctl.valid && !a_ctl.pixel;
   assign wr_data = {a_req.chan3, a_req.chan2, a_req.chan1, a_req.chan0};

   for (genvar k = 0; k < 8; k++) begin : g_bank
      l3d_ram #(
         .DEPTH (LUT_ENTRIES),
         .AW    (AW),
         .DW    (64)
      ) u_ram (
         .clock   (clock),
         .rd_en   (en),
         .rd_addr (a_addr[k]),
         .rd_data (rd_data[k]),
         .wr_en   (wr_en),
         .wr_addr (a_addr[0]),
         .wr_data (wr_data)
      );
   end

   // control alongside the registered bank read
   stage_ctl_type          s8_ctl_ff;
   logic signed [15:0]     s8_alpha_ff;
   logic [FRAC_BITS-1:0]   s8_wx_ff, s8_wy_ff, s8_wz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_ctl_ff <= '0;
      end else if (en) begin
         s8_ctl_ff <= a_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s8_alpha_ff <= a_req.chan3;
         s8_wx_ff    <= a_wx;
         s8_wy_ff    <= a_wy;
         s8_wz_ff    <= a_wz;
      end
   end

   l3d_interp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_interp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_ctl    (s8_ctl_ff),
      .in_alpha  (s8_alpha_ff),
      .in_wx     (s8_wx_ff),
      .in_wy     (s8_wy_ff),
      .in_wz     (s8_wz_ff),
      .corner    (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
